@@ src/utf8db_pkg.sv @@
// Shared types and constants for the bounded UTF-8 decoder.
package utf8db_pkg;

    localparam int CP_W      = 21;
    localparam int SYMS_W    = 16;
    localparam int BYTES_W   = 20;
    localparam int LEN_W     = 3;
    localparam int PEND_W    = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [SYMS_W-1:0]  SYMS_MAX  = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SYMBOLS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_AT_NUL = 8'd1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2,
        ST_NUL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic               symbol_valid;
        logic [CP_W-1:0]    code_point;
        logic [1:0]         status;
        logic               string_done;
        logic [SYMS_W-1:0]  symbols_done;
        logic [BYTES_W-1:0] bytes_done;
    } out_item_t;

    typedef struct packed {
        logic [CP_W-1:0]    accumulator;
        logic [PEND_W-1:0]  pending;
        logic [LEN_W-1:0]   seq_len;
        logic [SYMS_W-1:0]  symbol_count;
        logic [BYTES_W-1:0] byte_count;
        logic               stopped;
        status_t            stop_reason;
    } dec_state_t;

    typedef struct packed {
        logic [SYMS_W-1:0] max_symbols;
        logic              stop_at_nul;
    } dec_cfg_t;

endpackage

@@ src/utf8db_step.sv @@
// Combinational decode of one byte against the string state.
module utf8db_step (
    input  utf8db_pkg::dec_state_t state_cur,
    input  utf8db_pkg::dec_cfg_t   cfg,
    input  utf8db_pkg::in_item_t   item,
    output utf8db_pkg::dec_state_t state_next,
    output utf8db_pkg::out_item_t  result
);

    logic [7:0]                      b;
    logic [utf8db_pkg::LEN_W-1:0]    lead_len;
    logic [6:0]                      lead_bits;
    logic                            sym_done;
    logic [utf8db_pkg::LEN_W-1:0]    sym_bytes;
    logic [utf8db_pkg::BYTES_W:0]    byte_sum;
    utf8db_pkg::dec_state_t          st;

    assign b = item.in_byte;

    always_comb begin
        lead_len  = '0;
        lead_bits = '0;
        if (b[7] == 1'b0) begin
            lead_len  = 3'd1;
            lead_bits = b[6:0];
        end else if (b[7:5] == 3'b110) begin
            lead_len  = 3'd2;
            lead_bits = {2'b00, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            lead_len  = 3'd3;
            lead_bits = {3'b000, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            lead_len  = 3'd4;
            lead_bits = {4'b0000, b[2:0]};
        end
    end

    always_comb begin
        st        = state_cur;
        sym_done  = 1'b0;
        sym_bytes = '0;
        result    = '0;

        if (!state_cur.stopped) begin
            if (state_cur.pending == '0) begin
                if (cfg.stop_at_nul && b == 8'h00) begin
                    st.stopped     = 1'b1;
                    st.stop_reason = utf8db_pkg::ST_NUL;
                end else if (state_cur.symbol_count >= cfg.max_symbols) begin
                    st.stopped     = 1'b1;
                    st.stop_reason = utf8db_pkg::ST_FULL;
                end else if (lead_len == 3'd0) begin
                    st.stopped     = 1'b1;
                    st.stop_reason = utf8db_pkg::ST_BAD;
                end else if (lead_len == 3'd1) begin
                    sym_done          = 1'b1;
                    sym_bytes         = 3'd1;
                    result.code_point = {14'd0, lead_bits};
                end else begin
                    st.accumulator = {14'd0, lead_bits};
                    st.pending     = utf8db_pkg::PEND_W'(lead_len - 3'd1);
                    st.seq_len     = lead_len;
                end
            end else begin
                if (b[7:6] != 2'b10) begin
                    st.stopped     = 1'b1;
                    st.stop_reason = utf8db_pkg::ST_BAD;
                end else begin
                    st.accumulator = {state_cur.accumulator[14:0], b[5:0]};
                    st.pending     = state_cur.pending - 2'd1;
                    if (st.pending == '0) begin
                        sym_done          = 1'b1;
                        sym_bytes         = state_cur.seq_len;
                        result.code_point = st.accumulator;
                        st.accumulator    = '0;
                        st.seq_len        = '0;
                    end
                end
            end
            // a sequence cut off by the end of the string
            if (!st.stopped && item.last_byte && st.pending != '0) begin
                st.stopped     = 1'b1;
                st.stop_reason = utf8db_pkg::ST_BAD;
            end
        end

        byte_sum = {1'b0, st.byte_count} + (utf8db_pkg::BYTES_W + 1)'(sym_bytes);
        if (sym_done) begin
            if (st.symbol_count != utf8db_pkg::SYMS_MAX) begin
                st.symbol_count = st.symbol_count + 16'd1;
            end
            if (byte_sum > {1'b0, utf8db_pkg::BYTES_MAX}) begin
                st.byte_count = utf8db_pkg::BYTES_MAX;
            end else begin
                st.byte_count = byte_sum[utf8db_pkg::BYTES_W-1:0];
            end
        end

        result.symbol_valid = sym_done;
        result.status       = st.stopped ? st.stop_reason : utf8db_pkg::ST_OK;
        result.string_done  = item.last_byte;
        result.symbols_done = st.symbol_count;
        result.bytes_done   = st.byte_count;

        state_next = st;
        if (item.last_byte) begin
            state_next = '0;
        end
    end

endmodule

@@ src/utf8_decoder_bounded.sv @@
// Top level of the bounded UTF-8 decoder: input register, decode step, result register.
//
// Streaming UTF-8 decoder taking one byte per item and returning one result
// per item. Each byte sits in an input register, is decoded against the
// string state by a short block of masks and shifts, and lands in a result
// register. Throughput is one byte per cycle unless a full result register
// waits on m_ready. The input side keeps accepting while a result waits, and
// stalls only when both registers are full and m_ready is low. max_symbols
// (index 0) and stop_at_nul (index 1) are written through the cfg port; the
// user must write them only while no string bytes are in flight, as the block
// itself does not enforce this.
module utf8_decoder_bounded (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  utf8db_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output utf8db_pkg::out_item_t               m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [utf8db_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [utf8db_pkg::CFG_DAT_W-1:0]    cfg_data
);

    utf8db_pkg::dec_cfg_t    cfg_reg;
    utf8db_pkg::dec_state_t  state_reg;
    utf8db_pkg::dec_state_t  state_next;
    utf8db_pkg::in_item_t    in_reg;
    logic                    in_vld_reg;
    utf8db_pkg::out_item_t   out_reg;
    utf8db_pkg::out_item_t   out_next;
    logic                    out_vld_reg;
    logic                    advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    utf8db_step u_step (
        .state_cur  (state_reg),
        .cfg        (cfg_reg),
        .item       (in_reg),
        .state_next (state_next),
        .result     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_symbols <= utf8db_pkg::SYMS_MAX;
            cfg_reg.stop_at_nul <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == utf8db_pkg::REG_MAX_SYMBOLS) begin
                cfg_reg.max_symbols <= cfg_data;
            end else if (cfg_index == utf8db_pkg::REG_STOP_AT_NUL) begin
                cfg_reg.stop_at_nul <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the bounded UTF-8 decoder.
module tb_top;

    typedef struct packed {
        bit                                 is_reg;
        logic [utf8db_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [utf8db_pkg::CFG_DAT_W-1:0]   reg_val;
        utf8db_pkg::in_item_t               item;
        bit                                 pinned;
        utf8db_pkg::out_item_t              want;
    } plan_row_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    utf8db_pkg::in_item_t               s_data = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    utf8db_pkg::out_item_t              m_data;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [utf8db_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [utf8db_pkg::CFG_DAT_W-1:0]   cfg_data = '0;

    // decoder copy: configuration and per-string state
    logic [utf8db_pkg::SYMS_W-1:0]  lim_symbols = utf8db_pkg::SYMS_MAX;
    logic                           nul_ends = 1'b0;
    logic [utf8db_pkg::CP_W-1:0]    acc = '0;
    logic [utf8db_pkg::PEND_W-1:0]  cont_left = '0;
    logic [utf8db_pkg::LEN_W-1:0]   seq_bytes = '0;
    logic [utf8db_pkg::SYMS_W-1:0]  n_syms = '0;
    logic [utf8db_pkg::BYTES_W-1:0] n_bytes = '0;
    logic                           halted = 1'b0;
    utf8db_pkg::status_t            halt_why = utf8db_pkg::ST_OK;

    utf8db_pkg::out_item_t reports_due[$];
    utf8db_pkg::out_item_t got, want, predicted;
    plan_row_t             plan[$];
    bit                    pin_on = 1'b0;
    utf8db_pkg::out_item_t pin_want = '0;
    int                    n_mismatch = 0;
    int                    src_idle_pct = 0;
    int                    snk_idle_pct = 0;
    int                    holds_asked = 0;
    int                    holds_taken = 0;
    int                    hold_left = 0;

    utf8_decoder_bounded dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic void stop_string(utf8db_pkg::status_t why);
        halted = 1'b1;
        halt_why = why;
    endfunction

    function automatic void tally_symbol(logic [utf8db_pkg::LEN_W-1:0] k);
        logic [utf8db_pkg::BYTES_W:0] sum;
        if (n_syms != utf8db_pkg::SYMS_MAX) n_syms = n_syms + 16'd1;
        sum = {1'b0, n_bytes} + (utf8db_pkg::BYTES_W + 1)'(k);
        n_bytes = (sum > {1'b0, utf8db_pkg::BYTES_MAX}) ? utf8db_pkg::BYTES_MAX
                                                        : sum[utf8db_pkg::BYTES_W-1:0];
    endfunction

    function automatic utf8db_pkg::out_item_t decode_byte(utf8db_pkg::in_item_t it);
        utf8db_pkg::out_item_t         r;
        logic [7:0]                    b;
        logic [utf8db_pkg::LEN_W-1:0]  len;
        logic [6:0]                    lead;
        r = '0;
        b = it.in_byte;
        if (!halted) begin
            if (cont_left == '0) begin
                len = '0;
                lead = '0;
                if (b < 8'h80) begin
                    len = 3'd1;
                    lead = b[6:0];
                end else if ((b & 8'he0) == 8'hc0) begin
                    len = 3'd2;
                    lead = {2'b00, b[4:0]};
                end else if ((b & 8'hf0) == 8'he0) begin
                    len = 3'd3;
                    lead = {3'b000, b[3:0]};
                end else if ((b & 8'hf8) == 8'hf0) begin
                    len = 3'd4;
                    lead = {4'b0000, b[2:0]};
                end
                if (nul_ends && b == 8'h00) begin
                    stop_string(utf8db_pkg::ST_NUL);
                end else if (n_syms >= lim_symbols) begin
                    // capacity reached: the lead byte is not consumed
                    stop_string(utf8db_pkg::ST_FULL);
                end else if (len == 3'd0) begin
                    stop_string(utf8db_pkg::ST_BAD);
                end else if (len == 3'd1) begin
                    r.symbol_valid = 1'b1;
                    r.code_point = {14'd0, lead};
                    tally_symbol(3'd1);
                end else begin
                    acc = {14'd0, lead};
                    cont_left = utf8db_pkg::PEND_W'(len - 3'd1);
                    seq_bytes = len;
                end
            end else begin
                if (b[7:6] != 2'b10) begin
                    stop_string(utf8db_pkg::ST_BAD);
                end else begin
                    acc = {acc[utf8db_pkg::CP_W-7:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == '0) begin
                        r.symbol_valid = 1'b1;
                        r.code_point = acc;
                        tally_symbol(seq_bytes);
                        acc = '0;
                        seq_bytes = '0;
                    end
                end
            end
            if (!halted && it.last_byte && cont_left != '0) stop_string(utf8db_pkg::ST_BAD);
        end
        r.status = halted ? halt_why : utf8db_pkg::ST_OK;
        r.string_done = it.last_byte;
        r.symbols_done = n_syms;
        r.bytes_done = n_bytes;
        if (it.last_byte) begin
            acc = '0;
            cont_left = '0;
            seq_bytes = '0;
            n_syms = '0;
            n_bytes = '0;
            halted = 1'b0;
            halt_why = utf8db_pkg::ST_OK;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        n_mismatch++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
    endtask

    // check the result first, then record the prediction for a new item
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = m_data;
            if (reports_due.size() == 0) begin
                n_mismatch++;
                $display("%0t: unexpected result, expected none, got %0h", $time, got);
            end else begin
                want = reports_due.pop_front();
                if (got.symbol_valid !== want.symbol_valid)
                    note_mismatch("symbol_valid", 32'(want.symbol_valid),
                                  32'(got.symbol_valid));
                if (got.code_point !== want.code_point)
                    note_mismatch("code_point", 32'(want.code_point), 32'(got.code_point));
                if (got.status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.string_done !== want.string_done)
                    note_mismatch("string_done", 32'(want.string_done),
                                  32'(got.string_done));
                if (got.symbols_done !== want.symbols_done)
                    note_mismatch("symbols_done", 32'(want.symbols_done),
                                  32'(got.symbols_done));
                if (got.bytes_done !== want.bytes_done)
                    note_mismatch("bytes_done", 32'(want.bytes_done), 32'(got.bytes_done));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            predicted = decode_byte(s_data);
            reports_due.push_back(pin_on ? pin_want : predicted);
        end
    end

    // receiver: long hold on request, random idling otherwise
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_taken != holds_asked) begin
            m_ready <= 1'b0;
            hold_left <= 300;
            holds_taken <= holds_taken + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic push_byte(input utf8db_pkg::in_item_t it, input bit pinned,
                             input utf8db_pkg::out_item_t exp_r);
        @(negedge aclk);
        pin_on = pinned;
        pin_want = exp_r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the input until every result is back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [utf8db_pkg::CFG_IDX_W-1:0] idx,
                             input logic [utf8db_pkg::CFG_DAT_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == utf8db_pkg::REG_MAX_SYMBOLS) lim_symbols = val;
        else if (idx == utf8db_pkg::REG_STOP_AT_NUL) nul_ends = val[0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void row_byte(logic [7:0] b, bit last);
        plan.push_back('{is_reg: 1'b0, reg_idx: '0, reg_val: '0, item: {b, last},
                         pinned: 1'b0, want: '0});
    endfunction

    function automatic void row_check(logic [7:0] b, bit last, utf8db_pkg::out_item_t r);
        plan.push_back('{is_reg: 1'b0, reg_idx: '0, reg_val: '0, item: {b, last},
                         pinned: 1'b1, want: r});
    endfunction

    function automatic void row_reg(logic [utf8db_pkg::CFG_IDX_W-1:0] idx,
                                    logic [utf8db_pkg::CFG_DAT_W-1:0] val);
        plan.push_back('{is_reg: 1'b1, reg_idx: idx, reg_val: val, item: '0,
                         pinned: 1'b0, want: '0});
    endfunction

    // well-formed string of random symbols, sometimes broken on purpose
    task automatic send_string(inout int n_sent);
        logic [7:0] seq[$];
        int n_sym, len, pos, i;
        n_sym = $urandom_range(1, 10);
        repeat (n_sym) begin
            len = $urandom_range(1, 4);
            case (len)
                1: seq.push_back(8'($urandom_range(0, 127)));
                2: seq.push_back(8'hc0 | 8'($urandom_range(0, 31)));
                3: seq.push_back(8'he0 | 8'($urandom_range(0, 15)));
                default: seq.push_back(8'hf0 | 8'($urandom_range(0, 7)));
            endcase
            repeat (len - 1) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        pos = $urandom_range(0, seq.size() - 1);
        case ($urandom_range(0, 9))
            0: seq[pos] = 8'($urandom_range(0, 255));
            1: seq[pos] = 8'h00;
            2: seq[pos] = $urandom_range(0, 1) ? 8'h80 | 8'($urandom_range(0, 63))
                                               : 8'hf8 | 8'($urandom_range(0, 7));
            3: while (seq.size() > pos + 1) seq.delete(seq.size() - 1);
            default: ;
        endcase
        for (i = 0; i < seq.size(); i++)
            push_byte({seq[i], i == seq.size() - 1}, 1'b0, '0);
        n_sent += seq.size();
    endtask

    initial begin
        int phase, seg, n_sent;
        bit paused;
        plan_row_t pr;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // result fields: {valid, code point, status, done, symbols, bytes}
        row_byte(8'h00, 0);
        row_byte(8'h7f, 0);
        row_byte(8'hc2, 0);
        row_byte(8'ha9, 0);
        row_byte(8'he2, 0);
        row_byte(8'h82, 0);
        row_byte(8'hac, 0);
        row_byte(8'hf4, 0);
        row_byte(8'h8f, 0);
        row_byte(8'hbf, 0);
        row_check(8'hbf, 1, {1'b1, 21'h10ffff, utf8db_pkg::ST_OK, 1'b1, 16'd5, 20'd11});
        row_byte(8'hf7, 0);
        row_byte(8'hbf, 0);
        row_byte(8'hbf, 0);
        row_check(8'hbf, 1, {1'b1, 21'h1fffff, utf8db_pkg::ST_OK, 1'b1, 16'd1, 20'd4});
        row_check(8'hff, 1, {1'b0, 21'h0, utf8db_pkg::ST_BAD, 1'b1, 16'd0, 20'd0});
        row_byte(8'h80, 0);
        row_check(8'h41, 1, {1'b0, 21'h0, utf8db_pkg::ST_BAD, 1'b1, 16'd0, 20'd0});
        row_byte(8'hc3, 0);
        row_check(8'h00, 1, {1'b0, 21'h0, utf8db_pkg::ST_BAD, 1'b1, 16'd0, 20'd0});
        row_byte(8'h41, 0);
        row_check(8'he2, 1, {1'b0, 21'h0, utf8db_pkg::ST_BAD, 1'b1, 16'd1, 20'd1});
        row_reg(utf8db_pkg::REG_MAX_SYMBOLS, 16'd1);
        row_check(8'h41, 1, {1'b1, 21'h41, utf8db_pkg::ST_OK, 1'b1, 16'd1, 20'd1});
        row_byte(8'h41, 0);
        row_check(8'h42, 1, {1'b0, 21'h0, utf8db_pkg::ST_FULL, 1'b1, 16'd1, 20'd1});
        row_reg(utf8db_pkg::REG_MAX_SYMBOLS, 16'd0);
        row_reg(utf8db_pkg::REG_STOP_AT_NUL, 16'd1);
        row_check(8'h00, 1, {1'b0, 21'h0, utf8db_pkg::ST_NUL, 1'b1, 16'd0, 20'd0});

        src_idle_pct = 10;
        snk_idle_pct = 84;
        while (plan.size() != 0) begin
            pr = plan.pop_front();
            if (pr.is_reg) begin
                drain();
                write_reg(pr.reg_idx, pr.reg_val);
            end else begin
                push_byte(pr.item, pr.pinned, pr.want);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 84 : 0;
            snk_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 10 : 0;
            for (seg = 0; seg < 4; seg++) begin
                drain();
                case (seg)
                    0: write_reg(utf8db_pkg::REG_MAX_SYMBOLS, utf8db_pkg::SYMS_MAX);
                    1: write_reg(utf8db_pkg::REG_MAX_SYMBOLS, 16'($urandom_range(1, 6)));
                    2: write_reg(utf8db_pkg::REG_MAX_SYMBOLS, 16'($urandom_range(0, 65535)));
                    default: write_reg(utf8db_pkg::REG_MAX_SYMBOLS,
                                       16'($urandom_range(1, 3)));
                endcase
                write_reg(utf8db_pkg::REG_STOP_AT_NUL, 16'((seg + phase) % 2));
                // stall the receiver while the sender keeps offering
                if (phase == 2 && seg == 0) holds_asked++;
                n_sent = 0;
                paused = 0;
                while (n_sent < 125) begin
                    send_string(n_sent);
                    if (!paused && n_sent > 62) begin
                        drain();
                        paused = 1;
                    end
                end
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (n_mismatch == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(8 * 200000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/utf8db_pkg.sv
src/utf8db_step.sv
src/utf8_decoder_bounded.sv
test/tb_top.sv
